@@ rtl/ese_pkg.sv @@
// ----------------------------------------------------------------------------
// ese_pkg: shared types and constants of the encoder speed EMA filter
// Register indexes, field widths and the configuration bundle that the
// register file hands to the channel datapath.
// ----------------------------------------------------------------------------
package ese_pkg;

  localparam int RAW_W      = 16;          // raw count sample and speed width
  localparam int ACC_W      = 32;          // Q16.16 accumulator width
  localparam int ALPHA_W    = 16;          // Q0.16 weight width
  localparam int ZR_W       = 2;           // zero-run counter width
  localparam int ALPHA_REGS = 2;           // channels that own an alpha register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd19661;
  localparam logic [ZR_W-1:0]    ZR_STALL    = 2'd2;   // zero run that means stall

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_CH0   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_CH1   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 2'd2;

  typedef struct packed {
    logic [ALPHA_REGS-1:0][ALPHA_W-1:0] alpha;
    logic [ALPHA_REGS-1:0]              enable;
    logic [ALPHA_REGS-1:0]              clear;   // one-cycle pulse per channel
  } cfg_t;

endpackage

@@ rtl/ese_regs.sv @@
// ----------------------------------------------------------------------------
// ese_regs: configuration register file
// Holds the per-channel alpha weights and the enable mask, and pulses a
// clear for each channel whose state a write re-initializes.
// ----------------------------------------------------------------------------
module ese_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [ese_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [ese_pkg::CFG_DATA_W-1:0] wr_data,
  output ese_pkg::cfg_t                cfg
);
  import ese_pkg::*;

  logic [ALPHA_REGS-1:0][ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic [ALPHA_REGS-1:0]              enable_r, enable_nxt;
  logic [ALPHA_REGS-1:0]              clear;

  always_comb begin
    alpha_nxt  = alpha_r;
    enable_nxt = enable_r;
    clear      = '0;
    if (wr_en) begin
      case (wr_index)
        REG_ALPHA_CH0: begin
          alpha_nxt[0] = wr_data[ALPHA_W-1:0];
          clear[0]     = 1'b1;
        end
        REG_ALPHA_CH1: begin
          alpha_nxt[1] = wr_data[ALPHA_W-1:0];
          clear[1]     = 1'b1;
        end
        REG_ENABLE_MASK: begin
          enable_nxt = wr_data[ALPHA_REGS-1:0];
          clear      = wr_data[ALPHA_REGS-1:0];
        end
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= {ALPHA_REGS{ALPHA_RESET}};
      enable_r <= '0;
    end else begin
      alpha_r  <= alpha_nxt;
      enable_r <= enable_nxt;
    end
  end

  assign cfg.alpha  = alpha_r;
  assign cfg.enable = enable_r;
  assign cfg.clear  = clear;

endmodule

@@ rtl/ese_core.sv @@
// ----------------------------------------------------------------------------
// ese_core: per-channel state and filter datapath
// Reads the channel's accumulator and zero run, computes the new state and
// the speed in one pass, and writes the state back when the beat advances.
// ----------------------------------------------------------------------------
module ese_core #(
  parameter int CHANNELS = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ese_pkg::cfg_t              cfg,
  input  logic                       adv,
  input  logic                       ch,
  input  logic [ese_pkg::RAW_W-1:0]  raw,
  output logic [ese_pkg::RAW_W-1:0]  speed
);
  import ese_pkg::*;

  logic [CHANNELS-1:0][ACC_W-1:0] acc_r;
  logic [CHANNELS-1:0][ZR_W-1:0]  zr_r;

  logic [ACC_W-1:0]       acc_sel;
  logic [ZR_W-1:0]        zr_sel;
  logic [ALPHA_W-1:0]     alpha;
  logic                   ch_ok;
  logic                   raw_zero;
  logic [ZR_W-1:0]        zr_inc;
  logic [ZR_W-1:0]        zr_new;
  logic                   stall;
  logic [ALPHA_W:0]       wgt_old;
  logic signed [ACC_W-1:0]   acc_s;
  logic signed [ALPHA_W+1:0] wgt_old_s;
  logic signed [ALPHA_W+1:0] alpha_s;
  logic signed [RAW_W-1:0]   raw_s;
  logic signed [49:0]        prod_old;
  logic signed [RAW_W+ALPHA_W+1:0] prod_new;
  logic signed [49:0]        blend_sum;
  logic [ACC_W-1:0]       acc_new;

  // Select the addressed channel's state
  always_comb begin
    acc_sel = '0;
    zr_sel  = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (32'(ch) == c) begin
        acc_sel = acc_r[c];
        zr_sel  = zr_r[c];
      end
    end
  end

  assign alpha    = cfg.alpha[ch];
  assign ch_ok    = (32'(ch) < CHANNELS) && cfg.enable[ch];
  assign raw_zero = (raw == '0);
  assign zr_inc   = (zr_sel < ZR_STALL) ? zr_sel + 1'b1 : zr_sel;
  assign zr_new   = raw_zero ? zr_inc : '0;
  assign stall    = raw_zero && (zr_inc >= ZR_STALL);

  // Blend: (acc*(1-alpha) + raw*alpha) in Q16.16, rounded half up
  assign wgt_old   = 17'h10000 - {1'b0, alpha};
  assign acc_s     = signed'(acc_sel);
  assign wgt_old_s = signed'({1'b0, wgt_old});
  assign alpha_s   = signed'({2'b00, alpha});
  assign raw_s     = signed'(raw);
  assign prod_old  = acc_s * wgt_old_s;
  assign prod_new  = raw_s * alpha_s;
  assign blend_sum = prod_old + 50'(signed'({prod_new, 16'h0000})) + 50'sd32768;

  always_comb begin
    if (stall) begin
      acc_new = '0;
    end else if ((alpha == '0) || (acc_sel == '0)) begin
      acc_new = {raw, 16'h0000};
    end else begin
      acc_new = blend_sum[47:16];
    end
  end

  // Integer part of a 32-bit Q16.16 value always fits 16 bits: no clamp hit
  assign speed = (ch_ok && !stall) ? acc_new[ACC_W-1:16] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      zr_r  <= '0;
    end else begin
      for (int c = 0; c < CHANNELS; c++) begin
        if ((c < ALPHA_REGS) && cfg.clear[c[0]]) begin
          acc_r[c] <= '0;
          zr_r[c]  <= '0;
        end else if (adv && ch_ok && (32'(ch) == c)) begin
          acc_r[c] <= acc_new;
          zr_r[c]  <= zr_new;
        end
      end
    end
  end

endmodule

@@ rtl/encoder_speed_ema_filter.sv @@
// ----------------------------------------------------------------------------
// encoder_speed_ema_filter: per-channel exponential moving average of speed
// Filters raw signed encoder count samples in Q16.16 with a per-channel
// weight, detects stalls on two zero samples in a row and returns the
// integer part of the filtered value.
// ----------------------------------------------------------------------------
//
//   channel | direction | beat contents
//   --------+-----------+----------------------------------------------
//   in_     | sink      | in_channel, in_raw_count
//   out_    | source    | out_channel, out_speed
//   cfg_    | sink      | cfg_index, cfg_data (register write)
//
// One beat per cycle sustained while out_ready stays high; each beat passes
// the input register, then the result register. The filter step between them
// is one 32x18 and one 16x18 signed multiply feeding a three-term add.
// Reset (synchronous, rst_n low) loads alpha 19661, disables all channels
// and clears every accumulator and zero run.
// A stall on out_ holds the result register, then the input register; in_
// keeps taking beats while either stage has room.
// cfg_ accepts a write every cycle.
//
module encoder_speed_ema_filter #(
  parameter int CHANNELS = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_channel,
  input  logic [ese_pkg::RAW_W-1:0]      in_raw_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_channel,
  output logic [ese_pkg::RAW_W-1:0]      out_speed,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ese_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ese_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ese_pkg::*;

  cfg_t cfg;

  // Input stage
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_ch_r;
  logic [RAW_W-1:0] s1_raw_r;
  // Result stage
  logic             out_valid_r, out_valid_nxt;
  logic             out_ch_r;
  logic [RAW_W-1:0] out_speed_r;

  logic             s1_adv;
  logic             in_acc;
  logic [RAW_W-1:0] speed;

  assign cfg_ready = 1'b1;

  ese_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Filter step runs on the input stage; state commits when the beat moves on
  ese_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .adv   (s1_adv),
    .ch    (s1_ch_r),
    .raw   (s1_raw_r),
    .speed (speed)
  );

  // Advance the input stage whenever the result register is empty or draining
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: capture on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r  <= in_channel;
      s1_raw_r <= in_raw_count;
    end
    if (s1_adv) begin
      out_ch_r    <= s1_ch_r;
      out_speed_r <= speed;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_channel = out_ch_r;
  assign out_speed   = out_speed_r;

endmodule

@@ sim/tb_encoder_speed_ema_filter.sv @@
// ----------------------------------------------------------------------------
// tb_encoder_speed_ema_filter: self-checking testbench of the speed filter
// Drives count samples and register writes through valid/ready ports. A
// behavioral Q16.16 filter per channel predicts every speed beat, and each
// result is checked in order against it. Directed cases come first, then
// random traffic under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_encoder_speed_ema_filter;
  import ese_pkg::*;

  localparam int DRAIN_CYCLES = 6;        // slack past the block's input and result registers
  localparam int CYCLE_LIMIT  = 300000;   // far above the slowest legal run
  localparam int SEGMENTS     = 4;        // register settings per idle phase
  localparam int SEG_SAMPLES  = 84;       // samples per register setting

  // Index that decodes to no register; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct {
    logic             channel;
    logic [RAW_W-1:0] speed;
  } speed_beat_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic                  in_channel   = 1'b0;
  logic [RAW_W-1:0]      in_raw_count = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic                  out_channel;
  logic [RAW_W-1:0]      out_speed;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // Predicted filter state, one entry per channel.
  logic [ALPHA_W-1:0]      alpha_q [2] = '{ALPHA_RESET, ALPHA_RESET};
  logic [1:0]              enable_q    = '0;
  logic signed [ACC_W-1:0] acc_q   [2] = '{'0, '0};
  logic [ZR_W-1:0]         zero_run_q [2] = '{'0, '0};

  speed_beat_t expected_speeds [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int samples_sent   = 0;
  int speeds_checked = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  encoder_speed_ema_filter #(.CHANNELS(2)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_channel   (in_channel),
    .in_raw_count (in_raw_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_channel  (out_channel),
    .out_speed    (out_speed),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Abort a hung run; the limit covers every phase at its worst stall mix.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: stall at random in the share of cycles the phase asks for.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void clear_channel(input int ch);
    acc_q[ch]      = '0;
    zero_run_q[ch] = '0;
  endfunction

  // Track a register write as the block sees it at the handshake.
  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0]  idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ALPHA_CH0, REG_ALPHA_CH1: begin
        alpha_q[idx[0]] = data[ALPHA_W-1:0];
        clear_channel(idx[0]);
      end
      REG_ENABLE_MASK: begin
        // Enabling a channel re-initializes it; a dropped bit keeps state.
        enable_q = data[1:0];
        for (int c = 0; c < 2; c++)
          if (enable_q[c]) clear_channel(c);
      end
      default: ;  // unmapped index: drop the write
    endcase
  endfunction

  // Advance one channel's EMA by a sample and return the speed it yields.
  function automatic logic [RAW_W-1:0] filter_sample(input logic ch,
                                                     input logic signed [RAW_W-1:0] raw);
    longint blend;
    if (!enable_q[ch]) return '0;
    if (raw == 0) begin
      if (zero_run_q[ch] < ZR_STALL) zero_run_q[ch] = zero_run_q[ch] + 1'b1;
      if (zero_run_q[ch] >= ZR_STALL) begin
        // Second zero in a row: stalled, drop the history.
        acc_q[ch] = '0;
        return '0;
      end
    end else begin
      zero_run_q[ch] = '0;
    end
    if (alpha_q[ch] == 0 || acc_q[ch] == 0) begin
      acc_q[ch] = {raw, 16'h0000};
    end else begin
      blend = longint'(acc_q[ch]) * (longint'(65536) - longint'(alpha_q[ch]))
            + longint'(raw) * 65536 * longint'(alpha_q[ch]) + 32768;
      acc_q[ch] = ACC_W'(blend >>> 16);
    end
    // Integer part of a 32-bit Q16.16 value always fits in 16 bits.
    return acc_q[ch][ACC_W-1:16];
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted beat, check every result beat
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    speed_beat_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        want.channel = in_channel;
        want.speed   = filter_sample(in_channel, in_raw_count);
        expected_speeds.push_back(want);
      end
      if (out_valid && out_ready) begin
        speeds_checked++;
        if (expected_speeds.size() == 0) begin
          $error("result beat with nothing expected: out_channel %0d out_speed %0d",
                 out_channel, $signed(out_speed));
          error_count++;
        end else begin
          want = expected_speeds.pop_front();
          if (out_channel !== want.channel) begin
            $error("out_channel mismatch: expected %0d, actual %0d",
                   want.channel, out_channel);
            error_count++;
          end
          if (out_speed !== want.speed) begin
            $error("out_speed mismatch: expected %0d, actual %0d",
                   $signed(want.speed), $signed(out_speed));
            error_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Send one sample beat; idle first at the phase's rate, hold until taken.
  task automatic send_sample(input logic ch, input logic [RAW_W-1:0] raw);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_channel   <= ch;
    in_raw_count <= raw;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // Hold the sender until every sent beat has its result back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (speeds_checked < samples_sent) @(posedge clk);
  endtask

  // Write one register with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ALPHA_W-1:0] pick_alpha();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'h8000;
      default: return ALPHA_W'($urandom);
    endcase
  endfunction

  // Zeros often enough that stalls and single zeros both show up.
  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(9))
      0, 1:    return '0;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      4, 5, 6: return RAW_W'($urandom_range(200)) - 16'd100;
      default: return RAW_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Disabled after reset, unmapped writes dropped, reset alpha in use.
  task automatic test_reset_state();
    send_sample(1'b0, 16'h7FFF);
    send_sample(1'b1, 16'h8000);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    write_reg(REG_ENABLE_MASK, 16'h0003);
    send_sample(1'b0, 16'd100);          // empty accumulator: load
    send_sample(1'b0, 16'd200);          // blend at reset alpha
    send_sample(1'b0, 16'd0);            // single zero still blends
    send_sample(1'b0, 16'd0);            // second zero: stall
    send_sample(1'b0, 16'd0);            // stall holds
    send_sample(1'b0, 16'hFFFF);         // restart from a negative load
    send_sample(1'b1, 16'h8000);
    send_sample(1'b1, 16'h7FFF);
  endtask

  // Alpha extremes: pass-through, heaviest and lightest weight.
  task automatic test_alpha_extremes();
    write_reg(REG_ALPHA_CH0, 16'h0000);
    send_sample(1'b0, 16'd5);
    send_sample(1'b0, -16'sd7);
    send_sample(1'b0, 16'd0);
    send_sample(1'b0, 16'd12);
    write_reg(REG_ALPHA_CH1, 16'hFFFF);
    send_sample(1'b1, 16'h7FFF);
    send_sample(1'b1, 16'h8000);
    send_sample(1'b1, 16'd1);
    write_reg(REG_ALPHA_CH1, 16'h0001);
    send_sample(1'b1, 16'h8000);
    send_sample(1'b1, 16'h7FFF);
  endtask

  // Disabled channel gives zero while the other keeps filtering.
  task automatic test_channel_disable();
    write_reg(REG_ENABLE_MASK, 16'hFFFD);  // upper bits are not stored
    send_sample(1'b1, 16'd1234);
    send_sample(1'b0, 16'h8000);
    send_sample(1'b0, 16'h8000);
  endtask

  // Random traffic in segments, new register values between segments.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    logic [1:0] mask;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int s = 0; s < SEGMENTS; s++) begin
      if ($urandom_range(1)) write_reg(REG_ALPHA_CH0, pick_alpha());
      if ($urandom_range(1)) write_reg(REG_ALPHA_CH1, pick_alpha());
      if ($urandom_range(7) == 0) write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
      // Mostly both channels on so the filter does real work.
      mask = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : 2'b11;
      write_reg(REG_ENABLE_MASK, {14'($urandom), mask});
      for (int i = 0; i < SEG_SAMPLES; i++) begin
        send_sample(1'($urandom_range(1)), pick_raw());
        if ($urandom_range(60) == 0) wait_for_results();
      end
    end
  endtask

  // Hold the sender until the pipe is empty, then resume on live state.
  task automatic test_drain_pause();
    send_idle_pct  = 0;
    recv_stall_pct = 50;
    send_sample(1'b0, 16'd300);
    send_sample(1'b1, -16'sd300);
    wait_for_results();
    send_sample(1'b0, 16'd400);
    send_sample(1'b1, -16'sd400);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_alpha_extremes();
    test_channel_disable();
    test_random_traffic(0, 0);
    test_random_traffic(50, 0);
    test_random_traffic(0, 50);
    test_random_traffic(15, 15);
    test_drain_pause();

    // Drain, then give stray beats a chance to show up.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_speeds.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ese_pkg.sv
rtl/ese_regs.sv
rtl/ese_core.sv
rtl/encoder_speed_ema_filter.sv
sim/tb_encoder_speed_ema_filter.sv
